// ===== src/sfve_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and the command type of the stanza field value extractor
// no dependencies; used by every other file of the block

package sfve_pkg;

	// sizes
	localparam int NAME_MAX_CHARS = 16;
	localparam int PENDING_DEPTH  = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 64;
	localparam int TGT_LEN_W      = 5;

	// characters with a meaning to the parser
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TGT_LEN,
		REG_NAME_LOW,
		REG_NAME_HIGH,
		REG_JOIN_MODE
	} cfg_reg_t;

	// parser phase
	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_SKIP_LINE,
		PH_NAME,
		PH_VALUE,
		PH_VALUE_EOL,
		PH_IGNORE
	} phase_t;

	// what the back end does with a command
	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_EMIT,
		OP_DROP
	} cmd_op_t;

	// one command from the parser to the output side
	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] val;
		logic       status;
		logic       found;
	} cmd_t;

endpackage

// ===== src/sfve_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces of the stanza field value extractor
// depends on sfve_pkg for the configuration port widths

interface sfve_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stanza_end;

	modport source (output valid, output in_byte, output stanza_end, input ready);
	modport sink (input valid, input in_byte, input stanza_end, output ready);
endinterface

interface sfve_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_status;
	logic       field_found;
	logic       run_last;

	modport source (output valid, output out_byte, output is_status, output field_found,
		output run_last, input ready);
	modport sink (input valid, input out_byte, input is_status, input field_found,
		input run_last, output ready);
endinterface

interface sfve_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sfve_pkg::CFG_IDX_W-1:0]  index;
	logic [sfve_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/sfve_front.sv =====
`timescale 1ns / 1ps
// parser front end: configuration registers, line and name tracking, command generation
// depends on sfve_pkg and sfve_if

module sfve_front (
	input  logic           clk,
	input  logic           arst_n,
	sfve_cfg_if.sink       cfg,
	sfve_in_if.sink        stanza,
	input  logic           q_full,
	output logic           q_push,
	output sfve_pkg::cmd_t q_cmd
);

	localparam logic [sfve_pkg::TGT_LEN_W-1:0] NAME_MAX =
		sfve_pkg::TGT_LEN_W'(sfve_pkg::NAME_MAX_CHARS);

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	// configuration registers
	logic [sfve_pkg::TGT_LEN_W-1:0] tgt_len_q;
	logic [15:0][7:0]               name_chars_q;
	logic                           join_lf_q;

	// parser state
	sfve_pkg::phase_t               ph_q, ph_d;
	logic [sfve_pkg::TGT_LEN_W-1:0] pos_q, pos_d;
	logic                           match_q, match_d;
	logic                           match_done_q, match_done_d;
	logic                           emitted_q, emitted_d;
	logic                           skip_q, skip_d;

	logic                           accept;
	logic [7:0]                     c;
	logic                           c_lf, c_colon, c_blank, c_trail;
	logic [sfve_pkg::TGT_LEN_W-1:0] eff_pos;
	logic                           eff_match;
	logic [7:0]                     tgt_char;
	logic                           char_ok, name_hit, name_step, take_match;
	logic [7:0]                     v;
	logic                           emit_go, emit_skip, v_trail;
	sfve_pkg::cmd_op_t              op;

	assign cfg.ready    = 1'b1;
	assign stanza.ready = !q_full;
	assign accept       = stanza.valid && stanza.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_len_q    <= '0;
			name_chars_q <= '0;
			join_lf_q    <= 1'b0;
		end else if (cfg.valid) begin
			unique case (sfve_pkg::cfg_reg_t'(cfg.index))
				sfve_pkg::REG_TGT_LEN:   tgt_len_q <= cfg.data[sfve_pkg::TGT_LEN_W-1:0];
				sfve_pkg::REG_NAME_LOW:  name_chars_q[7:0] <= cfg.data;
				sfve_pkg::REG_NAME_HIGH: name_chars_q[15:8] <= cfg.data;
				sfve_pkg::REG_JOIN_MODE: join_lf_q <= cfg.data[0];
			endcase
		end
	end

	// byte classes
	assign c       = stanza.in_byte;
	assign c_lf    = c == sfve_pkg::CH_LF;
	assign c_colon = c == sfve_pkg::CH_COLON;
	assign c_blank = c == sfve_pkg::CH_SPACE || c == sfve_pkg::CH_TAB;
	assign c_trail = c_blank || c == sfve_pkg::CH_CR;

	// name compare; a new line restarts position and match
	assign eff_pos    = (ph_q == sfve_pkg::PH_LINE_START) ? '0 : pos_q;
	assign eff_match  = (ph_q == sfve_pkg::PH_LINE_START) ? 1'b1 : match_q;
	assign tgt_char   = name_chars_q[eff_pos[3:0]];
	assign char_ok    = eff_pos < tgt_len_q && eff_pos < NAME_MAX
		&& fold_case(c) == fold_case(tgt_char);
	assign name_hit   = !match_done_q && eff_match && eff_pos == tgt_len_q
		&& tgt_len_q <= NAME_MAX;
	assign name_step  = !c_lf && (ph_q == sfve_pkg::PH_NAME
		|| (ph_q == sfve_pkg::PH_LINE_START && !c_trail));
	assign take_match = name_step && c_colon && name_hit;

	// value byte candidate; a continuation marker becomes the joiner
	assign v         = (ph_q == sfve_pkg::PH_VALUE_EOL)
		? (join_lf_q ? sfve_pkg::CH_LF : sfve_pkg::CH_SPACE) : c;
	assign emit_go   = (ph_q == sfve_pkg::PH_VALUE && !c_lf && !(skip_q && c_blank))
		|| (ph_q == sfve_pkg::PH_VALUE_EOL && c_blank);
	assign emit_skip = !emitted_q && (v == sfve_pkg::CH_SPACE || v == sfve_pkg::CH_TAB);
	assign v_trail   = v == sfve_pkg::CH_SPACE || v == sfve_pkg::CH_TAB
		|| v == sfve_pkg::CH_CR;

	// next state
	always_comb begin
		ph_d         = ph_q;
		pos_d        = pos_q;
		match_d      = match_q;
		match_done_d = match_done_q;
		emitted_d    = emitted_q;
		skip_d       = skip_q;
		unique case (ph_q)
			sfve_pkg::PH_LINE_START, sfve_pkg::PH_NAME: begin
				if (c_lf) begin
					ph_d = sfve_pkg::PH_LINE_START;
				end else if (!name_step) begin
					ph_d = sfve_pkg::PH_SKIP_LINE;
				end else begin
					pos_d   = eff_pos;
					match_d = eff_match;
					ph_d    = sfve_pkg::PH_NAME;
					if (c_colon) begin
						if (name_hit) begin
							match_done_d = 1'b1;
							ph_d         = sfve_pkg::PH_VALUE;
							emitted_d    = 1'b0;
							skip_d       = 1'b0;
						end else begin
							ph_d = sfve_pkg::PH_SKIP_LINE;
						end
					end else begin
						if (!char_ok)
							match_d = 1'b0;
						if (eff_pos <= NAME_MAX)
							pos_d = eff_pos + 1'b1;
					end
				end
			end
			sfve_pkg::PH_SKIP_LINE: begin
				if (c_lf)
					ph_d = sfve_pkg::PH_LINE_START;
			end
			sfve_pkg::PH_VALUE: begin
				if (c_lf) begin
					ph_d = sfve_pkg::PH_VALUE_EOL;
				end else if (emit_go) begin
					skip_d = 1'b0;
					if (!emit_skip)
						emitted_d = 1'b1;
				end
			end
			sfve_pkg::PH_VALUE_EOL: begin
				if (c_blank) begin
					if (!emit_skip)
						emitted_d = 1'b1;
					skip_d = !join_lf_q;
					ph_d   = sfve_pkg::PH_VALUE;
				end else begin
					ph_d = sfve_pkg::PH_IGNORE;
				end
			end
			default: ph_d = sfve_pkg::PH_IGNORE;
		endcase
		// end of stanza returns the parser to its idle state
		if (stanza.stanza_end) begin
			ph_d         = sfve_pkg::PH_LINE_START;
			pos_d        = '0;
			match_d      = 1'b1;
			match_done_d = 1'b0;
			emitted_d    = 1'b0;
			skip_d       = 1'b0;
		end
	end

	// command for the output side
	always_comb begin
		op = sfve_pkg::OP_NONE;
		if (emit_go && !emit_skip)
			op = v_trail ? sfve_pkg::OP_PUSH : sfve_pkg::OP_EMIT;
		if (ph_q == sfve_pkg::PH_VALUE_EOL && !c_blank)
			op = sfve_pkg::OP_DROP;
		q_cmd.op     = op;
		q_cmd.val    = v;
		q_cmd.status = stanza.stanza_end;
		q_cmd.found  = match_done_q || take_match;
		q_push       = accept && (op != sfve_pkg::OP_NONE || stanza.stanza_end);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q         <= sfve_pkg::PH_LINE_START;
			pos_q        <= '0;
			match_q      <= 1'b1;
			match_done_q <= 1'b0;
			emitted_q    <= 1'b0;
			skip_q       <= 1'b0;
		end else if (accept) begin
			ph_q         <= ph_d;
			pos_q        <= pos_d;
			match_q      <= match_d;
			match_done_q <= match_done_d;
			emitted_q    <= emitted_d;
			skip_q       <= skip_d;
		end
	end

endmodule

// ===== src/sfve_queue.sv =====
`timescale 1ns / 1ps
// command queue between the parser front end and the output back end
// depends on sfve_pkg for the command type

module sfve_queue #(
	parameter int DEPTH = sfve_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfve_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output sfve_pkg::cmd_t head_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

	sfve_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_push, do_pop;

	assign full       = level_q == LVL_FULL;
	assign head_valid = level_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				level_q <= level_q + 1'b1;
			else if (do_pop && !do_push)
				level_q <= level_q - 1'b1;
		end
	end

endmodule

// ===== src/sfve_back.sv =====
`timescale 1ns / 1ps
// output back end: trailing blank run buffer, flush sequencing, result register
// depends on sfve_pkg and sfve_if

module sfve_back #(
	parameter int PENDING_DEPTH = sfve_pkg::PENDING_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  sfve_pkg::cmd_t head_cmd,
	output logic           pop,
	sfve_out_if.source     result
);

	localparam int CNT_W = $clog2(PENDING_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PENDING_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PENDING_DEPTH - 2);

	logic [PENDING_DEPTH-1:0][7:0] run_q;
	logic [CNT_W-1:0]              count_q, count_d;
	logic                          stat_pend_q, stat_d;

	logic             produce, do_pop, shift, wr_en, fire, out_space;
	logic [CNT_W-1:0] wr_idx;
	logic [7:0]       res_byte;
	logic             res_status, res_found, res_last;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             is_status_q, found_q, last_q;

	assign out_space = !out_valid_q || result.ready;

	// one step of the head command
	always_comb begin
		produce    = 1'b0;
		do_pop     = 1'b0;
		shift      = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = count_q;
		count_d    = count_q;
		stat_d     = stat_pend_q;
		res_byte   = run_q[0];
		res_status = 1'b0;
		res_found  = 1'b0;
		res_last   = 1'b0;
		if (stat_pend_q) begin
			produce    = 1'b1;
			res_byte   = 8'h00;
			res_status = 1'b1;
			res_found  = head_cmd.found;
			res_last   = 1'b1;
			count_d    = '0;
			stat_d     = 1'b0;
			do_pop     = 1'b1;
		end else begin
			unique case (head_cmd.op)
				sfve_pkg::OP_PUSH: begin
					if (count_q == CNT_FULL) begin
						// run buffer full: oldest held byte goes out early
						produce  = 1'b1;
						res_last = !head_cmd.status;
						shift    = 1'b1;
						wr_en    = 1'b1;
						wr_idx   = CNT_LAST;
						stat_d   = head_cmd.status;
						do_pop   = !head_cmd.status;
					end else begin
						wr_en   = 1'b1;
						count_d = count_q + 1'b1;
						do_pop  = 1'b1;
						if (head_cmd.status) begin
							produce    = 1'b1;
							res_byte   = 8'h00;
							res_status = 1'b1;
							res_found  = head_cmd.found;
							res_last   = 1'b1;
							count_d    = '0;
						end
					end
				end
				sfve_pkg::OP_EMIT: begin
					produce = 1'b1;
					if (count_q != '0) begin
						// held run is not trailing after all
						shift   = 1'b1;
						count_d = count_q - 1'b1;
					end else begin
						res_byte = head_cmd.val;
						res_last = !head_cmd.status;
						stat_d   = head_cmd.status;
						do_pop   = !head_cmd.status;
					end
				end
				sfve_pkg::OP_DROP, sfve_pkg::OP_NONE: begin
					count_d = '0;
					do_pop  = 1'b1;
					if (head_cmd.status) begin
						produce    = 1'b1;
						res_byte   = 8'h00;
						res_status = 1'b1;
						res_found  = head_cmd.found;
						res_last   = 1'b1;
					end
				end
			endcase
		end
	end

	assign fire = head_valid && (!produce || out_space);
	assign pop  = fire && do_pop;

	// run buffer, oldest byte at entry zero
	always_ff @(posedge clk) begin
		if (fire) begin
			if (shift) begin
				for (int i = 0; i < PENDING_DEPTH - 1; i++)
					run_q[i] <= run_q[i + 1];
			end
			if (wr_en)
				run_q[wr_idx] <= head_cmd.val;
		end
	end

	// sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			stat_pend_q <= 1'b0;
		end else if (fire) begin
			count_q     <= count_d;
			stat_pend_q <= stat_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_space)
			out_valid_q <= head_valid && produce;
	end

	always_ff @(posedge clk) begin
		if (out_space && head_valid && produce) begin
			out_byte_q  <= res_byte;
			is_status_q <= res_status;
			found_q     <= res_found;
			last_q      <= res_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_byte    = out_byte_q;
	assign result.is_status   = is_status_q;
	assign result.field_found = found_q;
	assign result.run_last    = last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("run buffer count beyond its limit");

	a_status_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		stat_pend_q |-> head_valid)
		else $error("status owed with no command at the queue head");

	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && stat_pend_q) |=> count_q == '0)
		else $error("run buffer not emptied by the status beat");
`endif

endmodule

// ===== src/stanza_field_value_extractor_top.sv =====
`timescale 1ns / 1ps
// top level of the stanza field value extractor: parser, command queue, output side
// depends on sfve_pkg, sfve_if, sfve_front, sfve_queue and sfve_back
//
//   channel   dir   beat carries
//   cfg       in    index, data (register write)
//   stanza    in    in_byte, stanza_end
//   result    out   out_byte, is_status, field_found, run_last
//
// one stanza byte is taken per cycle while the command queue has room
// results leave at one per cycle while the receiver is ready; a value byte goes out
// after the held blank run before it, and a status beat after it as a beat of its own
// the run buffer, a shift line of PENDING_DEPTH bytes, sets the longest flush
// reset clears control state at once; no clearing pass, the run buffer is unset
// a stalled result holds the output register, the queue fills, then stanza.ready drops

module stanza_field_value_extractor_top #(
	parameter int PENDING_DEPTH = sfve_pkg::PENDING_DEPTH,
	parameter int QUEUE_DEPTH   = sfve_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sfve_cfg_if.sink   cfg,
	sfve_in_if.sink    stanza,
	sfve_out_if.source result
);

	logic           q_full, q_push, q_pop, head_valid;
	sfve_pkg::cmd_t q_cmd, head_cmd;

	// parser
	sfve_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.stanza (stanza),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	// command queue
	sfve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// output side
	sfve_back #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.result     (result)
	);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of stanza_field_value_extractor_top: random control stanzas in,
// every result beat predicted by a scoreboard class; depends on sfve_pkg, sfve_if and the rtl

module tb;

	localparam int HOLD_OFF_CYCLES      = 80;
	localparam int SETTLE_CYCLES        = 40;
	localparam int MAX_MISMATCH_REPORTS = 10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic       field_found;
		logic       run_last;
	} value_beat_t;

	// field value prediction and result checking
	class value_extract_board;
		logic [4:0]         tgt_len;
		logic [127:0]       name_chars;
		logic               join_lf;
		sfve_pkg::phase_t   phase;
		int unsigned        name_pos;
		bit                 name_ok;
		bit                 matched;
		bit                 value_started;
		bit                 skip_indent;
		logic [7:0]         blank_run [sfve_pkg::PENDING_DEPTH];
		int unsigned        blank_count;
		value_beat_t        step_beats[$];
		value_beat_t        value_beats_due[$];
		int unsigned        failures;
		int unsigned        beats_checked;
		int unsigned        beats_predicted;
		int unsigned        status_beats;
		int unsigned        found_count;
		int unsigned        overflow_flushes;

		function new();
			tgt_len = '0;
			name_chars = '0;
			join_lf = 1'b0;
			restart_stanza();
		endfunction

		function void set_reg(sfve_pkg::cfg_reg_t idx, logic [63:0] data);
			case (idx)
				sfve_pkg::REG_TGT_LEN: tgt_len = data[sfve_pkg::TGT_LEN_W-1:0];
				sfve_pkg::REG_NAME_LOW: name_chars[63:0] = data;
				sfve_pkg::REG_NAME_HIGH: name_chars[127:64] = data;
				default: join_lf = data[0];
			endcase
		endfunction

		function void restart_stanza();
			phase = sfve_pkg::PH_LINE_START;
			name_pos = 0;
			name_ok = 1'b1;
			matched = 1'b0;
			value_started = 1'b0;
			skip_indent = 1'b0;
			blank_count = 0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == sfve_pkg::CH_SPACE || c == sfve_pkg::CH_TAB;
		endfunction

		function bit is_trail(logic [7:0] c);
			return is_blank(c) || c == sfve_pkg::CH_CR;
		endfunction

		function logic [7:0] lower_case(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function void push_beat(logic [7:0] b, logic status, logic found);
			value_beat_t beat;
			beat.out_byte = b;
			beat.is_status = status;
			beat.field_found = found;
			beat.run_last = 1'b0;
			step_beats.push_back(beat);
		endfunction

		// one character of a field name, or the colon or line end that closes it
		function void match_name_char(logic [7:0] c);
			if (c == sfve_pkg::CH_LF) begin
				phase = sfve_pkg::PH_LINE_START;
			end else if (c == sfve_pkg::CH_COLON) begin
				if (!matched && name_ok && name_pos == tgt_len
						&& tgt_len <= sfve_pkg::NAME_MAX_CHARS) begin
					matched = 1'b1;
					phase = sfve_pkg::PH_VALUE;
					value_started = 1'b0;
					skip_indent = 1'b0;
					blank_count = 0;
				end else begin
					phase = sfve_pkg::PH_SKIP_LINE;
				end
			end else begin
				if (!(name_pos < tgt_len && name_pos < sfve_pkg::NAME_MAX_CHARS
						&& lower_case(c) == lower_case(name_chars[8*name_pos +: 8])))
					name_ok = 1'b0;
				if (name_pos <= sfve_pkg::NAME_MAX_CHARS)
					name_pos++;
			end
		endfunction

		// leading blanks dropped, blank runs held until a later byte ends them
		function void emit_value_char(logic [7:0] c);
			if (value_started || !is_blank(c)) begin
				value_started = 1'b1;
				if (is_trail(c)) begin
					if (blank_count >= sfve_pkg::PENDING_DEPTH - 1) begin
						push_beat(blank_run[0], 1'b0, 1'b0);
						for (int i = 0; i < sfve_pkg::PENDING_DEPTH - 1; i++)
							blank_run[i] = blank_run[i + 1];
						blank_count = sfve_pkg::PENDING_DEPTH - 2;
						overflow_flushes++;
					end
					blank_run[blank_count] = c;
					blank_count++;
				end else begin
					for (int i = 0; i < blank_count; i++)
						push_beat(blank_run[i], 1'b0, 1'b0);
					blank_count = 0;
					push_beat(c, 1'b0, 1'b0);
				end
			end
		endfunction

		// an accepted stanza beat: work out the result beats it causes
		function void take_stanza_byte(logic [7:0] c, logic is_last);
			value_beat_t tail;
			step_beats = {};
			case (phase)
				sfve_pkg::PH_LINE_START: begin
					if (is_trail(c)) begin
						phase = sfve_pkg::PH_SKIP_LINE;
					end else if (c != sfve_pkg::CH_LF) begin
						name_pos = 0;
						name_ok = 1'b1;
						phase = sfve_pkg::PH_NAME;
						match_name_char(c);
					end
				end
				sfve_pkg::PH_SKIP_LINE: begin
					if (c == sfve_pkg::CH_LF)
						phase = sfve_pkg::PH_LINE_START;
				end
				sfve_pkg::PH_NAME: match_name_char(c);
				sfve_pkg::PH_VALUE: begin
					if (c == sfve_pkg::CH_LF) begin
						phase = sfve_pkg::PH_VALUE_EOL;
					end else if (!(skip_indent && is_blank(c))) begin
						skip_indent = 1'b0;
						emit_value_char(c);
					end
				end
				sfve_pkg::PH_VALUE_EOL: begin
					if (is_blank(c)) begin
						emit_value_char(join_lf ? sfve_pkg::CH_LF : sfve_pkg::CH_SPACE);
						skip_indent = !join_lf;
						phase = sfve_pkg::PH_VALUE;
					end else begin
						blank_count = 0;
						phase = sfve_pkg::PH_IGNORE;
					end
				end
				default: phase = sfve_pkg::PH_IGNORE;
			endcase
			if (is_last) begin
				push_beat(8'h00, 1'b1, matched);
				status_beats++;
				if (matched)
					found_count++;
				restart_stanza();
			end
			if (step_beats.size() != 0) begin
				tail = step_beats.pop_back();
				tail.run_last = 1'b1;
				step_beats.push_back(tail);
			end
			foreach (step_beats[i])
				value_beats_due.push_back(step_beats[i]);
			beats_predicted += step_beats.size();
		endfunction

		// an accepted result beat against the oldest prediction
		function void check_result(value_beat_t got);
			value_beat_t want;
			beats_checked++;
			if (value_beats_due.size() == 0) begin
				failures++;
				if (failures <= MAX_MISMATCH_REPORTS)
					$display("beat %0d unexpected: byte %02h status %b found %b last %b",
						beats_checked, got.out_byte, got.is_status, got.field_found,
						got.run_last);
			end else begin
				want = value_beats_due.pop_front();
				if (got.out_byte !== want.out_byte || got.is_status !== want.is_status
						|| got.field_found !== want.field_found
						|| got.run_last !== want.run_last) begin
					failures++;
					if (failures <= MAX_MISMATCH_REPORTS)
						$display("beat %0d: want %02h %b %b %b, got %02h %b %b %b",
							beats_checked, want.out_byte, want.is_status, want.field_found,
							want.run_last, got.out_byte, got.is_status, got.field_found,
							got.run_last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sfve_cfg_if cfg_if ();
	sfve_in_if  stanza_if ();
	sfve_out_if result_if ();

	stanza_field_value_extractor_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.stanza (stanza_if),
		.result (result_if)
	);

	value_extract_board board = new();

	logic [7:0]   text[$];
	logic [4:0]   gen_tgt_len;
	logic [127:0] gen_name;
	bit           long_run_due;
	bit           hold_off_go;
	bit           hold_off;
	int           send_idle;
	int           recv_idle;
	int unsigned  bytes_sent;
	int unsigned  stanzas_sent;
	int unsigned  input_stall_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2_000_000;
		$display("stanza_field_value_extractor_top verification failed");
		$finish;
	end

	// receiver readiness, random or held off
	always @(negedge clk) begin
		result_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	// long receiver hold-off, counted here once requested
	initial begin
		hold_off = 1'b0;
		wait (hold_off_go);
		hold_off = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	// result beats
	always @(posedge clk) begin
		if (arst_n && result_if.valid === 1'b1 && result_if.ready)
			board.check_result({result_if.out_byte, result_if.is_status,
				result_if.field_found, result_if.run_last});
		if (hold_off && stanza_if.valid && !stanza_if.ready)
			input_stall_cycles++;
	end

	// stanza text generation
	function automatic logic [7:0] random_letter();
		logic [7:0] ch;
		ch = 8'("a" + $urandom_range(0, 25));
		if ($urandom_range(0, 1) == 1)
			ch = ch ^ 8'h20;
		return ch;
	endfunction

	function automatic logic [7:0] random_trail();
		logic [7:0] ch;
		case ($urandom_range(0, 2))
			0: ch = sfve_pkg::CH_SPACE;
			1: ch = sfve_pkg::CH_TAB;
			default: ch = sfve_pkg::CH_CR;
		endcase
		return ch;
	endfunction

	function automatic logic [127:0] random_name();
		logic [127:0] n;
		for (int i = 0; i < sfve_pkg::NAME_MAX_CHARS; i++)
			n[8*i +: 8] = random_letter();
		return n;
	endfunction

	function automatic void put_str(string s);
		foreach (s[i])
			text.push_back(s[i]);
	endfunction

	// wanted name in random case, now and then one character short or long; else random letters
	function automatic void put_name(bit wanted);
		int unsigned n;
		int unsigned twist;
		logic [7:0] ch;
		if (wanted) begin
			n = gen_tgt_len > sfve_pkg::NAME_MAX_CHARS ? sfve_pkg::NAME_MAX_CHARS : gen_tgt_len;
			twist = $urandom_range(0, 7);
			if (twist == 0 && n > 0)
				n--;
			for (int i = 0; i < n; i++) begin
				ch = gen_name[8*i +: 8];
				if ((ch | 8'h20) >= "a" && (ch | 8'h20) <= "z" && $urandom_range(0, 1) == 1)
					ch = ch ^ 8'h20;
				text.push_back(ch);
			end
			if (twist == 1)
				text.push_back(random_letter());
		end else begin
			repeat ($urandom_range(1, 6))
				text.push_back(random_letter());
		end
	endfunction

	// value text: words, blank runs (one long run per phase, which may overflow), odd bytes
	function automatic void put_value();
		int unsigned run;
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 5))
				0, 1, 2: begin
					repeat ($urandom_range(1, 4))
						text.push_back(8'($urandom_range(8'h21, 8'h7E)));
				end
				3, 4: begin
					run = long_run_due ? $urandom_range(14, 20) : $urandom_range(1, 3);
					long_run_due = 1'b0;
					repeat (run)
						text.push_back(random_trail());
				end
				default: text.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	function automatic void put_cont_lines();
		repeat ($urandom_range(0, 1)) begin
			text.push_back($urandom_range(0, 1) ? sfve_pkg::CH_TAB : sfve_pkg::CH_SPACE);
			repeat ($urandom_range(0, 2))
				text.push_back($urandom_range(0, 1) ? sfve_pkg::CH_TAB : sfve_pkg::CH_SPACE);
			put_value();
			text.push_back(sfve_pkg::CH_LF);
		end
	endfunction

	// mostly well-formed fields, some skipped lines and noise
	function automatic void build_stanza();
		text = {};
		repeat ($urandom_range(1, 2)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					put_name(1'b1);
					text.push_back(sfve_pkg::CH_COLON);
					put_value();
					text.push_back(sfve_pkg::CH_LF);
					put_cont_lines();
				end
				5, 6: begin
					put_name(1'b0);
					text.push_back(sfve_pkg::CH_COLON);
					put_value();
					text.push_back(sfve_pkg::CH_LF);
					put_cont_lines();
				end
				7: begin
					text.push_back(random_trail());
					put_value();
					text.push_back(sfve_pkg::CH_LF);
				end
				8: begin
					put_name(1'b0);
					text.push_back(sfve_pkg::CH_LF);
				end
				default: begin
					repeat ($urandom_range(1, 4))
						text.push_back(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1) == 1)
						text.push_back(sfve_pkg::CH_LF);
				end
			endcase
		end
		// stanza may also end in the middle of a line
		if ($urandom_range(0, 3) == 0 && text.size() > 1)
			void'(text.pop_back());
	endfunction

	// one stanza beat with random idling in front
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < send_idle) begin
			stanza_if.valid <= 1'b0;
			@(negedge clk);
		end
		stanza_if.valid <= 1'b1;
		stanza_if.in_byte <= b;
		stanza_if.stanza_end <= is_last;
		do
			@(posedge clk);
		while (!stanza_if.ready);
		board.take_stanza_byte(b, is_last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_stanza();
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1);
		stanzas_sent++;
	endtask

	// wait for every predicted beat, then let the block go quiet
	task automatic settle();
		stanza_if.valid <= 1'b0;
		while (board.value_beats_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// all four registers, block idle
	task automatic configure(input logic [4:0] len, input logic [127:0] name, input logic keep);
		sfve_pkg::cfg_reg_t idx;
		logic [63:0] data;
		gen_tgt_len = len;
		gen_name = name;
		for (int i = 0; i < 4; i++) begin
			idx = sfve_pkg::cfg_reg_t'(i);
			case (idx)
				sfve_pkg::REG_TGT_LEN: data = 64'(len);
				sfve_pkg::REG_NAME_LOW: data = name[63:0];
				sfve_pkg::REG_NAME_HIGH: data = name[127:64];
				default: data = 64'(keep);
			endcase
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx;
			cfg_if.data <= data;
			do
				@(posedge clk);
			while (!cfg_if.ready);
			board.set_reg(idx, data);
			@(negedge clk);
		end
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random_phase(input int s_idle, input int r_idle,
			input int unsigned min_bytes, input int unsigned min_beats);
		int unsigned byte_mark;
		int unsigned beat_mark;
		int unsigned rounds;
		send_idle = s_idle;
		recv_idle = r_idle;
		long_run_due = 1'b1;
		byte_mark = bytes_sent;
		beat_mark = board.beats_predicted;
		rounds = 0;
		while ((bytes_sent - byte_mark < min_bytes
				|| board.beats_predicted - beat_mark < min_beats) && rounds < 40) begin
			build_stanza();
			send_stanza();
			rounds++;
		end
		settle();
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = sfve_pkg::REG_TGT_LEN;
		cfg_if.data = '0;
		stanza_if.valid = 1'b0;
		stanza_if.in_byte = '0;
		stanza_if.stanza_end = 1'b0;
		result_if.ready = 1'b0;
		hold_off_go = 1'b0;
		send_idle = 17;
		recv_idle = 45;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers at reset: an empty name matches a line that starts with the colon
		text = {};
		text.push_back(sfve_pkg::CH_COLON);
		put_str("x");
		send_stanza();
		settle();

		// indented line, line without colon, blanks around the value, zero and all-ones
		// bytes, kept continuation line, later field ignored
		configure(5'd2, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_4261}, 1'b1);
		text = {};
		text.push_back(sfve_pkg::CH_SPACE);
		put_str("x");
		text.push_back(sfve_pkg::CH_LF);
		put_str("q");
		text.push_back(sfve_pkg::CH_LF);
		put_str("Ab");
		text.push_back(sfve_pkg::CH_COLON);
		text.push_back(sfve_pkg::CH_TAB);
		text.push_back(sfve_pkg::CH_SPACE);
		put_str("a");
		text.push_back(8'h00);
		text.push_back(8'hFF);
		text.push_back(sfve_pkg::CH_SPACE);
		text.push_back(sfve_pkg::CH_CR);
		text.push_back(sfve_pkg::CH_LF);
		text.push_back(sfve_pkg::CH_SPACE);
		put_str("c");
		text.push_back(sfve_pkg::CH_LF);
		put_str("ab");
		text.push_back(sfve_pkg::CH_COLON);
		put_str("z");
		send_stanza();
		settle();

		// folded values, sender idling less than receiver
		configure(5'd7, random_name(), 1'b0);
		run_random_phase(17, 45, 12, 3);

		// full-length name, kept line breaks, receiver idling less
		configure(5'(sfve_pkg::NAME_MAX_CHARS), random_name(), 1'b1);
		run_random_phase(45, 17, 12, 3);

		// empty name; long result stall while the sender keeps offering
		configure(5'd0, random_name(), 1'b1);
		send_idle = 0;
		recv_idle = 0;
		text = {};
		text.push_back(sfve_pkg::CH_COLON);
		repeat (16)
			text.push_back(random_letter());
		text.push_back(sfve_pkg::CH_LF);
		put_str("z");
		hold_off_go = 1'b1;
		send_stanza();
		settle();

		// name longer than the limit never matches, even with every character equal
		configure(5'd31, '1, 1'b0);
		text = {};
		repeat (sfve_pkg::NAME_MAX_CHARS)
			text.push_back(8'hFF);
		text.push_back(sfve_pkg::CH_COLON);
		put_str("v");
		send_stanza();
		settle();

		$display("covered %0d stanzas, %0d stanza bytes, %0d result beats (%0d status, %0d found)",
			stanzas_sent, bytes_sent, board.beats_checked, board.status_beats, board.found_count);
		$display("run buffer overflow flushes %0d, input held back %0d cycles by a result stall",
			board.overflow_flushes, input_stall_cycles);
		if (board.failures == 0 && board.value_beats_due.size() == 0) begin
			$display("stanza_field_value_extractor_top verification clean");
		end else begin
			$display("%0d mismatches, %0d beats still expected", board.failures,
				board.value_beats_due.size());
			$display("stanza_field_value_extractor_top verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/sfve_pkg.sv
src/sfve_if.sv
src/sfve_front.sv
src/sfve_queue.sv
src/sfve_back.sv
src/stanza_field_value_extractor_top.sv
verif/tb.sv
